### hw/rtl/sbrt_pkg.sv
`default_nettype none

package sbrt_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int SERIAL_W = 31;
    localparam int CCOUNT_W = 2;

    // Defaults and sizes
    localparam int DEFAULT_TABLE_DEPTH = 8;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 2'd2;

    // Input action codes
    localparam logic ACTION_ARRIVE = 1'b0;
    localparam logic ACTION_RETURN = 1'b1;

    // Result status codes
    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_DROPPED  = 1'b1;

    // Command kinds handed from the front end to the table engine
    typedef enum logic {
        CMD_ARRIVE,
        CMD_RETURN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [ADDR_W-1:0]     addr;
        logic [SERIAL_W-1:0]   serial;
        logic                  consumer;
    } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/sbrt_front.sv
`default_nettype none

module sbrt_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          action,
    input  wire logic [sbrt_pkg::ADDR_W-1:0]   buf_addr,
    input  wire logic [sbrt_pkg::SERIAL_W-1:0] frame_serial,
    input  wire logic                          consumer,
    input  wire logic                          q_full,
    output logic                               push,
    output sbrt_pkg::cmd_t                     push_cmd
);
    import sbrt_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic take;

    // Hold one decoded word; stall the source only when the queue is full
    assign push     = valid_reg && !q_full;
    assign busy     = valid_reg && q_full;
    assign take     = start && !busy;
    assign push_cmd = cmd_reg;

    // Decode the incoming word; fields the action does not use are zeroed
    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next    = 1'b1;
            cmd_next.addr = buf_addr;
            unique case (action)
                ACTION_ARRIVE:
                begin
                    cmd_next.kind     = CMD_ARRIVE;
                    cmd_next.serial   = frame_serial;
                    cmd_next.consumer = 1'b0;
                end
                ACTION_RETURN:
                begin
                    cmd_next.kind     = CMD_RETURN;
                    cmd_next.serial   = '0;
                    cmd_next.consumer = consumer;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

### hw/rtl/sbrt_queue.sv
`default_nettype none

module sbrt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sbrt_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output sbrt_pkg::cmd_t      pop_cmd,
    output logic                not_empty
);
    import sbrt_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             buf_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = buf_mem[rd_ptr_reg];

    // Pointer and fill bookkeeping with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sbrt_back.sv
`default_nettype none

module sbrt_back #(
    parameter int TABLE_DEPTH = sbrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sbrt_pkg::CCOUNT_W-1:0] cfg_wdata,
    input  wire logic                          q_not_empty,
    input  wire sbrt_pkg::cmd_t                q_cmd,
    output logic                               q_pop,
    output logic                               result_strobe,
    output logic                               status,
    output logic [sbrt_pkg::ADDR_W-1:0]        released_addr,
    output logic [sbrt_pkg::SERIAL_W-1:0]      released_serial,
    output logic                               last
);
    import sbrt_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic                seen1;
        logic                seen0;
        logic [SERIAL_W-1:0] serial;
        logic [ADDR_W-1:0]   addr;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Entry storage, indexed by slot
    entry_t      tbl_mem [TABLE_DEPTH];
    entry_t      rd_data_reg;
    logic        mem_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    entry_t      mem_wdata;

    // Control state
    state_t              state_reg, state_next;
    logic [CCOUNT_W-1:0] ccount_reg, ccount_next;
    logic [SERIAL_W-1:0] lrs_reg, lrs_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    steps_reg, steps_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic                pend_valid_reg, pend_valid_next;

    // Registered outputs
    logic                strobe_reg, strobe_next;
    logic                status_reg, status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [SERIAL_W-1:0] out_serial_reg, out_serial_next;
    logic                last_reg, last_next;

    // Payload state: live slots newest first, return being walked, held result
    logic [SLOT_W-1:0]   order_reg [TABLE_DEPTH];
    logic [SLOT_W-1:0]   order_next [TABLE_DEPTH];
    logic [ADDR_W-1:0]   walk_addr_reg, walk_addr_next;
    logic                walk_cons_reg, walk_cons_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [SERIAL_W-1:0] pend_serial_reg, pend_serial_next;

    // Walk decision on the entry at the head of the order list
    logic              is_match, rel_match, rel_stale, keep;
    logic              seen0_new, seen1_new;
    logic [CCOUNT_W-1:0] marks;
    logic [SLOT_W-1:0] head_slot, free_slot;

    // Lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign head_slot = order_reg[0];
    assign is_match  = (rd_data_reg.addr == walk_addr_reg);
    assign seen0_new = rd_data_reg.seen0 | (is_match && !walk_cons_reg);
    assign seen1_new = rd_data_reg.seen1 | (is_match && walk_cons_reg);
    assign marks     = {1'b0, seen0_new} + {1'b0, seen1_new};
    assign rel_match = is_match && (marks == ccount_reg);
    assign rel_stale = !is_match && (rd_data_reg.serial < lrs_reg);
    assign keep      = !(rel_match || rel_stale);

    always_comb
    begin
        state_next       = state_reg;
        ccount_next      = ccount_reg;
        lrs_next         = lrs_reg;
        count_next       = count_reg;
        steps_next       = steps_reg;
        used_next        = used_reg;
        pend_valid_next  = pend_valid_reg;
        strobe_next      = 1'b0;
        status_next      = status_reg;
        out_addr_next    = out_addr_reg;
        out_serial_next  = out_serial_reg;
        last_next        = last_reg;
        walk_addr_next   = walk_addr_reg;
        walk_cons_next   = walk_cons_reg;
        pend_addr_next   = pend_addr_reg;
        pend_serial_next = pend_serial_reg;
        order_next       = order_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = free_slot;
        mem_wdata        = rd_data_reg;
        mem_raddr        = order_reg[0];

        if (cfg_we)
        begin
            ccount_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_ARRIVE:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                // Table full: bounce the arrival
                                strobe_next     = 1'b1;
                                status_next     = STATUS_DROPPED;
                                out_addr_next   = q_cmd.addr;
                                out_serial_next = q_cmd.serial;
                                last_next       = 1'b1;
                            end
                            else
                            begin
                                // Store in a free slot, push it as newest
                                mem_we           = 1'b1;
                                mem_waddr        = free_slot;
                                mem_wdata.seen1  = 1'b0;
                                mem_wdata.seen0  = 1'b0;
                                mem_wdata.serial = q_cmd.serial;
                                mem_wdata.addr   = q_cmd.addr;
                                used_next[free_slot] = 1'b1;
                                order_next[0]    = free_slot;
                                for (int j = 1; j < TABLE_DEPTH; j++)
                                begin
                                    order_next[j] = order_reg[j-1];
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_RETURN:
                        begin
                            walk_addr_next = q_cmd.addr;
                            walk_cons_next = q_cmd.consumer;
                            if (count_reg != '0)
                            begin
                                // Newest entry is read now, judged next cycle
                                steps_next = count_reg;
                                state_next = ST_WALK;
                            end
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Prefetch the entry that becomes head after this rotation
                mem_raddr = order_reg[1];
                if (is_match)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = head_slot;
                    mem_wdata.seen0 = seen0_new;
                    mem_wdata.seen1 = seen1_new;
                end
                if (rel_match)
                begin
                    lrs_next = rd_data_reg.serial;
                end
                if (!keep)
                begin
                    used_next[head_slot] = 1'b0;
                    count_next           = count_reg - 1'b1;
                    // Previous release goes out; this one waits to learn its last flag
                    if (pend_valid_reg)
                    begin
                        strobe_next     = 1'b1;
                        status_next     = STATUS_RELEASED;
                        out_addr_next   = pend_addr_reg;
                        out_serial_next = pend_serial_reg;
                        last_next       = 1'b0;
                    end
                    pend_valid_next  = 1'b1;
                    pend_addr_next   = rd_data_reg.addr;
                    pend_serial_next = rd_data_reg.serial;
                end
                // Rotate: head leaves the front, a kept head goes behind the live list
                for (int j = 0; j < TABLE_DEPTH - 1; j++)
                begin
                    order_next[j] = (keep && CNT_W'(j) == count_reg - 1'b1)
                                  ? head_slot : order_reg[j+1];
                end
                if (keep && CNT_W'(TABLE_DEPTH - 1) == count_reg - 1'b1)
                begin
                    order_next[TABLE_DEPTH-1] = head_slot;
                end
                steps_next = steps_reg - 1'b1;
                if (steps_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (pend_valid_reg)
                begin
                    strobe_next     = 1'b1;
                    status_next     = STATUS_RELEASED;
                    out_addr_next   = pend_addr_reg;
                    out_serial_next = pend_serial_reg;
                    last_next       = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ccount_reg     <= CCOUNT_RESET;
            lrs_reg        <= '0;
            count_reg      <= '0;
            steps_reg      <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            status_reg     <= STATUS_RELEASED;
            out_addr_reg   <= '0;
            out_serial_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ccount_reg     <= ccount_next;
            lrs_reg        <= lrs_next;
            count_reg      <= count_next;
            steps_reg      <= steps_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            status_reg     <= status_next;
            out_addr_reg   <= out_addr_next;
            out_serial_reg <= out_serial_next;
            last_reg       <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        order_reg       <= order_next;
        walk_addr_reg   <= walk_addr_next;
        walk_cons_reg   <= walk_cons_next;
        pend_addr_reg   <= pend_addr_next;
        pend_serial_reg <= pend_serial_next;
    end

    // Entry table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tbl_mem[mem_raddr];
    end

    assign result_strobe   = strobe_reg;
    assign status          = status_reg;
    assign released_addr   = out_addr_reg;
    assign released_serial = out_serial_reg;
    assign last            = last_reg;

    // Occupied slots and live count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == count_reg)
        else $error("slot occupancy does not match live count");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live count above table depth");

    // A drop is always the only word of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && status == STATUS_DROPPED) |-> last)
        else $error("drop result without last flag");

    // No release is left held between items
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held release outlived its walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |=> (count_reg <= $past(count_reg)))
        else $error("live count grew during a walk");

endmodule

`default_nettype wire

### hw/rtl/shared_buffer_release_tracker.sv
`default_nettype none

// Release tracker for frame buffers shared by up to two consumers. A word is
// taken when start is high and busy is low; results leave on result_strobe,
// one cycle each, and the receiver cannot stall them, so it must take every
// strobed word. An arrival is stored in the back end in the cycle that it
// leaves the two-entry command queue and gives no result unless the table is
// full, in which case one dropped word follows on the next cycle. A return
// walks all live entries in the back end (up to TABLE_DEPTH of them): the
// table sits in a memory with a single read port, so the walk from newest
// to oldest judges one entry per cycle, and a closing step flushes the final
// release with last set. Releases come out in walk order, at most one a cycle.
// busy rises only when both the front register and the queue are full.
module shared_buffer_release_tracker #(
    parameter int TABLE_DEPTH = sbrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          action,
    input  wire logic [sbrt_pkg::ADDR_W-1:0]   buf_addr,
    input  wire logic [sbrt_pkg::SERIAL_W-1:0] frame_serial,
    input  wire logic                          consumer,
    input  wire logic                          cfg_we,
    input  wire logic [sbrt_pkg::CCOUNT_W-1:0] cfg_wdata,
    output logic                               result_strobe,
    output logic                               status,
    output logic [sbrt_pkg::ADDR_W-1:0]        released_addr,
    output logic [sbrt_pkg::SERIAL_W-1:0]      released_serial,
    output logic                               last
);
    import sbrt_pkg::*;

    logic push, q_full, q_pop, q_not_empty;
    cmd_t push_cmd, q_cmd;

    sbrt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .buf_addr     (buf_addr),
        .frame_serial (frame_serial),
        .consumer     (consumer),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    sbrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_cmd),
        .not_empty (q_not_empty)
    );

    sbrt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .q_not_empty     (q_not_empty),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop),
        .result_strobe   (result_strobe),
        .status          (status),
        .released_addr   (released_addr),
        .released_serial (released_serial),
        .last            (last)
    );

endmodule

`default_nettype wire
